>>> hw/rtl/etw_pkg.sv
// shared types and constants for the eased tween interpolator
`default_nettype none

package etw_pkg;

    localparam int VALUE_W    = 32;
    localparam int DURATION_W = 24;
    localparam int STEP_W     = 17;
    localparam int CFG_IDX_W  = 2;
    // start and end difference, and the width of the multiplicand path
    localparam int DIFF_W     = 33;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_EASE,
        ST_BLEND,
        ST_OUT
    } etw_state_t;

    typedef enum logic [1:0] {
        EASE_LINEAR = 2'd0,
        EASE_IN     = 2'd1,
        EASE_OUT    = 2'd2,
        EASE_IN_OUT = 2'd3
    } etw_ease_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START    = 2'd0,
        REG_END      = 2'd1,
        REG_DURATION = 2'd2,
        REG_EASE     = 2'd3
    } etw_reg_t;

endpackage

`default_nettype wire

>>> hw/rtl/etw_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module etw_div #(
    parameter int NW = 24,
    parameter int QW = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [NW-1:0] dividend,
    input  wire logic [NW-1:0] divisor,
    output logic               done,
    output logic [QW-1:0]      quotient
);

    localparam int CW = $clog2(QW + 1);

    logic [NW-1:0] rem_reg, rem_next;
    logic [NW-1:0] dvs_reg, dvs_next;
    logic [QW-1:0] q_reg, q_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [NW:0]   trial;
    logic [NW:0]   trial_sub;
    logic          fits;

    always_comb begin
        trial     = {rem_reg, 1'b0};
        trial_sub = trial - {1'b0, dvs_reg};
        fits      = (trial >= {1'b0, dvs_reg});
    end

    always_comb begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            // dividend is below the divisor, so the remainder stays narrow
            rem_next  = dividend;
            dvs_next  = divisor;
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? trial_sub[NW-1:0] : trial[NW-1:0];
            q_next   = {q_reg[QW-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(QW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

>>> hw/rtl/etw_mul.sv
// bit-serial shift-add multiplier, unsigned multiplier by two's complement multiplicand
`default_nettype none

module etw_mul #(
    parameter int MPW = 17,
    parameter int MCW = 33
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [MPW-1:0]     mplier,
    input  wire logic [MCW-1:0]     mcand,
    output logic                    done,
    output logic [MCW+MPW:0]        product
);

    localparam int CW = $clog2(MPW + 1);

    logic [MCW:0]   acc_reg, acc_next;
    logic [MPW-1:0] low_reg, low_next;
    logic [MPW-1:0] mp_reg, mp_next;
    logic [MCW-1:0] mc_reg, mc_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;

    logic [MCW:0]   addend;
    logic [MCW+1:0] sum;

    always_comb begin
        addend = mp_reg[0] ? {mc_reg[MCW-1], mc_reg} : '0;
        sum    = {acc_reg[MCW], acc_reg} + {addend[MCW], addend};
    end

    always_comb begin
        acc_next  = acc_reg;
        low_next  = low_reg;
        mp_next   = mp_reg;
        mc_next   = mc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            acc_next  = '0;
            low_next  = '0;
            mp_next   = mplier;
            mc_next   = mcand;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // arithmetic shift right, low product bits collect from the top
            acc_next = sum[MCW+1:1];
            low_next = {sum[0], low_reg[MPW-1:1]};
            mp_next  = {1'b0, mp_reg[MPW-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(MPW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        acc_reg <= acc_next;
        low_reg <= low_next;
        mp_reg  <= mp_next;
        mc_reg  <= mc_next;
    end

    assign done    = done_reg;
    assign product = {acc_reg, low_reg};

endmodule

`default_nettype wire

>>> hw/rtl/eased_tween_interpolator.sv
// eased tween interpolator top level: configuration, tick sequencer and blend
// Each accepted tick adds its time step to the elapsed count (saturating at the duration),
// forms progress = elapsed/duration as a fraction with FRACTION_BITS bits, applies the
// quadratic ease selected by ease_mode and returns start + (end - start) * eased in Q16.16,
// together with is_done and finished_now. A tick in progress passes first through the
// bit-serial divider, then twice through the one bit-serial multiplier, which is used
// first for the ease and then for the blend. The tick that completes the tween skips the
// divider, and once done a tick is answered with the held end value. One tick is
// processed at a time; the next is taken while the previous result still waits in the
// output register. Configuration writes are always accepted at once and belong between
// ticks.
`default_nettype none

module eased_tween_interpolator import etw_pkg::*; #(
    parameter int TIME_BITS     = 24,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [VALUE_W-1:0]   cfg_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [STEP_W-1:0]    s_time_step_us,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [VALUE_W-1:0]        m_current_value,
    output logic                      m_is_done,
    output logic                      m_finished_now
);

    localparam int MPW = FRACTION_BITS + 1;
    localparam int PW  = DIFF_W + MPW + 1;
    localparam int BW  = FRACTION_BITS + 3;
    localparam int DW  = (TIME_BITS > DURATION_W) ? TIME_BITS : DURATION_W;
    localparam int SW  = ((TIME_BITS > STEP_W) ? TIME_BITS : STEP_W) + 1;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
    localparam logic [MPW-1:0]       ONE      = MPW'(1) << FRACTION_BITS;

    // configuration
    logic [VALUE_W-1:0]    start_value_reg;
    logic [VALUE_W-1:0]    end_value_reg;
    logic [DURATION_W-1:0] duration_reg;
    etw_ease_t             ease_reg;

    // sequencer and tween state
    etw_state_t            state_reg, state_next;
    logic [TIME_BITS-1:0]  elapsed_reg, elapsed_next;
    logic                  done_reg, done_next;
    logic                  fin_reg, fin_next;
    logic [VALUE_W-1:0]    held_reg, held_next;
    logic                  inout_hi_reg, inout_hi_next;

    // result register
    logic                  m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0]    m_value_reg, m_value_next;
    logic                  m_done_reg, m_done_next;
    logic                  m_fin_reg, m_fin_next;

    logic                  cfg_fire;
    logic                  s_fire;
    logic                  out_free;
    logic [DW-1:0]         dur_wide;
    logic [TIME_BITS-1:0]  dur;
    logic [SW-1:0]         sum_w;
    logic                  reaches;
    logic [TIME_BITS-1:0]  elapsed_sat;

    logic                  div_start;
    logic                  div_done;
    logic [FRACTION_BITS-1:0] div_q;
    logic                  mul_start;
    logic                  mul_done;
    logic [PW-1:0]         mul_product;
    logic                  blend_sel;
    logic                  out_load;

    logic [MPW-1:0]        p_sel;
    logic                  p_half;
    logic [BW-1:0]         ease_b;
    logic [BW-1:0]         e_raw;
    logic [BW-1:0]         e_adj;
    logic [MPW-1:0]        eased;
    logic [DIFF_W-1:0]     diff;
    logic [MPW-1:0]        mplier;
    logic [DIFF_W-1:0]     mcand;
    logic [VALUE_W-1:0]    blend_q;
    logic [VALUE_W-1:0]    blend_val;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // elapsed update: duration limited to the counter, sum saturates at the duration
    always_comb begin
        dur_wide    = DW'(duration_reg);
        dur         = (dur_wide > DW'(TIME_MAX)) ? TIME_MAX : dur_wide[TIME_BITS-1:0];
        sum_w       = SW'(elapsed_reg) + SW'(s_time_step_us);
        reaches     = (sum_w >= SW'(dur));
        elapsed_sat = reaches ? dur : sum_w[TIME_BITS-1:0];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (done_reg) begin
                        state_next = ST_OUT;
                    end else if (reaches) begin
                        state_next = ST_EASE;
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_EASE;
                end
            end
            ST_EASE: begin
                if (mul_done) begin
                    state_next = ST_BLEND;
                end
            end
            ST_BLEND: begin
                if (mul_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        mul_start = 1'b0;
        blend_sel = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                div_start = s_fire && !done_reg && !reaches;
                mul_start = s_fire && !done_reg && reaches;
            end
            ST_DIV: begin
                mul_start = div_done;
            end
            ST_EASE: begin
                blend_sel = 1'b1;
                mul_start = mul_done;
            end
            ST_BLEND: begin
            end
            ST_OUT: begin
                out_load = out_free;
            end
        endcase
    end

    // ease operand: progress times a mode dependent factor
    always_comb begin
        p_sel  = (state_reg == ST_DIV) ? {1'b0, div_q} : ONE;
        p_half = (p_sel < (ONE >> 1));
        case (ease_reg)
            EASE_LINEAR: ease_b = BW'(ONE);
            EASE_IN:     ease_b = BW'(p_sel);
            EASE_OUT:    ease_b = (BW'(ONE) << 1) - BW'(p_sel);
            EASE_IN_OUT: ease_b = p_half ? (BW'(p_sel) << 1)
                                         : (BW'(ONE) << 2) - (BW'(p_sel) << 1);
            default:     ease_b = BW'(ONE);
        endcase
    end

    always_comb begin
        e_raw     = mul_product[FRACTION_BITS +: BW];
        e_adj     = inout_hi_reg ? (e_raw - BW'(ONE)) : e_raw;
        eased     = e_adj[MPW-1:0];
        diff      = {end_value_reg[VALUE_W-1], end_value_reg}
                  - {start_value_reg[VALUE_W-1], start_value_reg};
        mplier    = blend_sel ? eased : p_sel;
        mcand     = blend_sel ? diff : DIFF_W'(ease_b);
        // floor of the signed product by the fraction width, kept modulo the value width
        blend_q   = mul_product[FRACTION_BITS +: VALUE_W];
        blend_val = start_value_reg + blend_q;
    end

    etw_div #(
        .NW(TIME_BITS),
        .QW(FRACTION_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(elapsed_sat),
        .divisor (dur),
        .done    (div_done),
        .quotient(div_q)
    );

    etw_mul #(
        .MPW(MPW),
        .MCW(DIFF_W)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mplier  (mplier),
        .mcand   (mcand),
        .done    (mul_done),
        .product (mul_product)
    );

    // register next values
    always_comb begin
        elapsed_next  = elapsed_reg;
        done_next     = done_reg;
        fin_next      = fin_reg;
        held_next     = held_reg;
        inout_hi_next = inout_hi_reg;
        m_valid_next  = m_valid_reg;
        m_value_next  = m_value_reg;
        m_done_next   = m_done_reg;
        m_fin_next    = m_fin_reg;
        if (s_fire) begin
            if (done_reg) begin
                fin_next = 1'b0;
            end else begin
                elapsed_next = elapsed_sat;
                done_next    = reaches;
                fin_next     = reaches;
            end
        end
        if (mul_start && !blend_sel) begin
            inout_hi_next = (ease_reg == EASE_IN_OUT) && !p_half;
        end
        if (state_reg == ST_BLEND && mul_done) begin
            held_next = blend_val;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
            m_value_next = held_reg;
            m_done_next  = done_reg;
            m_fin_next   = fin_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_value_reg <= '0;
            end_value_reg   <= '0;
            duration_reg    <= '0;
            ease_reg        <= EASE_LINEAR;
            state_reg       <= ST_IDLE;
            elapsed_reg     <= '0;
            done_reg        <= 1'b0;
            fin_reg         <= 1'b0;
            held_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_fire) begin
                unique case (cfg_index)
                    REG_START:    start_value_reg <= cfg_data;
                    REG_END:      end_value_reg   <= cfg_data;
                    REG_DURATION: duration_reg    <= cfg_data[DURATION_W-1:0];
                    REG_EASE:     ease_reg        <= etw_ease_t'(cfg_data[1:0]);
                endcase
            end
            state_reg   <= state_next;
            elapsed_reg <= elapsed_next;
            done_reg    <= done_next;
            fin_reg     <= fin_next;
            held_reg    <= held_next;
            m_valid_reg <= m_valid_next;
        end
        inout_hi_reg <= inout_hi_next;
        m_value_reg  <= m_value_next;
        m_done_reg   <= m_done_next;
        m_fin_reg    <= m_fin_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_current_value = m_value_reg;
    assign m_is_done       = m_done_reg;
    assign m_finished_now  = m_fin_reg;

    // only one tick in flight
    a_single_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready)
        else $error("tick accepted while another is in progress");

    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> done_reg)
        else $error("done flag cleared without reset");

    a_fin_implies_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (!m_fin_reg || m_done_reg))
        else $error("finished transaction without done");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide phase");

    a_mul_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == ST_EASE || state_reg == ST_BLEND))
        else $error("multiplier finished outside the ease or blend phase");

endmodule

`default_nettype wire

>>> test/etw_tween_checker.sv
// transaction checker for the eased tween interpolator: tween prediction and result comparison
module etw_tween_checker import etw_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VALUE_W-1:0]   cfg_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [STEP_W-1:0]    s_time_step_us,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [VALUE_W-1:0]   m_current_value,
    input  logic                 m_is_done,
    input  logic                 m_finished_now,
    output int                   mismatches,
    output int                   outstanding
);

    localparam int FRAC_W = 16;
    localparam logic [FRAC_W:0] UNIT = {1'b1, {FRAC_W{1'b0}}};

    typedef struct packed {
        logic [VALUE_W-1:0] current_value;
        logic               is_done;
        logic               finished_now;
    } tween_sample_t;

    // register copies
    logic signed [VALUE_W-1:0] start_q;
    logic signed [VALUE_W-1:0] end_q;
    logic [DURATION_W-1:0]     span_us;
    etw_ease_t                 shape_q;

    // tween state
    logic [DURATION_W-1:0]     elapsed_us;
    logic                      tween_done;
    logic [VALUE_W-1:0]        held_q;

    tween_sample_t expected_samples[$];
    int fail_count   = 0;
    int waiting_n    = 0;
    int results_seen = 0;

    assign mismatches  = fail_count;
    assign outstanding = waiting_n;

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] want_v,
                                   input logic [VALUE_W-1:0] got_v);
        $display("mismatch on result %0d: %s, expected %0h, got %0h",
                 results_seen, what, want_v, got_v);
        fail_count++;
    endtask

    function automatic logic [FRAC_W:0] shape_progress(input logic [FRAC_W:0] p,
                                                       input etw_ease_t mode);
        logic [63:0] pw;
        logic [63:0] one_w;
        logic [63:0] r;
        pw    = 64'(p);
        one_w = 64'(UNIT);
        case (mode)
            EASE_IN:  r = (pw * pw) >> FRAC_W;
            EASE_OUT: r = (pw * (2 * one_w - pw)) >> FRAC_W;
            EASE_IN_OUT: begin
                if (pw < one_w / 2)
                    r = (2 * pw * pw) >> FRAC_W;
                else
                    r = (((4 * one_w - 2 * pw) * pw) >> FRAC_W) - one_w;
            end
            default:  r = pw;
        endcase
        return r[FRAC_W:0];
    endfunction

    // start + floor((end - start) * e / one)
    function automatic logic [VALUE_W-1:0] mix_value(input logic [FRAC_W:0] e);
        longint span;
        longint prod;
        longint v;
        span = longint'(end_q) - longint'(start_q);
        prod = span * longint'(e);
        v    = longint'(start_q) + (prod >>> FRAC_W);
        return v[VALUE_W-1:0];
    endfunction

    function automatic tween_sample_t advance_tween(input logic [STEP_W-1:0] step);
        tween_sample_t                  r;
        logic [DURATION_W:0]            total;
        logic [FRAC_W:0]                p;
        logic [DURATION_W+FRAC_W-1:0]   quotient;
        logic                           finished;
        finished = 1'b0;
        if (!tween_done) begin
            total = {1'b0, elapsed_us} + (DURATION_W+1)'(step);
            if (total > {1'b0, span_us})
                total = {1'b0, span_us};
            elapsed_us = total[DURATION_W-1:0];
            if (span_us == '0 || elapsed_us >= span_us) begin
                p          = UNIT;
                tween_done = 1'b1;
                finished   = 1'b1;
            end else begin
                quotient = {elapsed_us, {FRAC_W{1'b0}}} / (DURATION_W+FRAC_W)'(span_us);
                p = (quotient > UNIT) ? UNIT : quotient[FRAC_W:0];
            end
            held_q = mix_value(shape_progress(p, shape_q));
        end
        r.current_value = held_q;
        r.is_done       = tween_done;
        r.finished_now  = finished;
        return r;
    endfunction

    always @(posedge aclk) begin
        tween_sample_t want;
        if (!aresetn) begin
            start_q    = '0;
            end_q      = '0;
            span_us    = '0;
            shape_q    = EASE_LINEAR;
            elapsed_us = '0;
            tween_done = 1'b0;
            held_q     = '0;
            expected_samples.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (etw_reg_t'(cfg_index))
                    REG_START:    start_q = cfg_data;
                    REG_END:      end_q   = cfg_data;
                    REG_DURATION: span_us = cfg_data[DURATION_W-1:0];
                    REG_EASE:     shape_q = etw_ease_t'(cfg_data[CFG_IDX_W-1:0]);
                    default: ;
                endcase
            end
            // retire first so a result never matches the tick taken on the same edge
            if (m_valid && m_ready) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch("result with no tick waiting", '0, m_current_value);
                end else begin
                    want = expected_samples.pop_front();
                    if (m_current_value !== want.current_value)
                        report_mismatch("current_value", want.current_value, m_current_value);
                    if (m_is_done !== want.is_done)
                        report_mismatch("is_done", VALUE_W'(want.is_done), VALUE_W'(m_is_done));
                    if (m_finished_now !== want.finished_now)
                        report_mismatch("finished_now", VALUE_W'(want.finished_now),
                                        VALUE_W'(m_finished_now));
                end
                results_seen++;
            end
            if (s_valid && s_ready)
                expected_samples.insert(expected_samples.size(),
                                        advance_tween(s_time_step_us));
        end
        waiting_n <= expected_samples.size();
    end

endmodule

>>> test/tb_eased_tween_interpolator.sv
// testbench top for the eased tween interpolator: clock, reset, tick stimulus and verdict
module tb_eased_tween_interpolator;
    import etw_pkg::*;

    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int RANDOM_TICKS = 1880;
    localparam logic [DURATION_W-1:0] DUR_FULL = '1;

    logic                 aclk           = 1'b0;
    logic                 aresetn        = 1'b0;
    logic                 cfg_valid      = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index      = '0;
    logic [VALUE_W-1:0]   cfg_data       = '0;
    logic                 s_valid        = 1'b0;
    logic                 s_ready;
    logic [STEP_W-1:0]    s_time_step_us = '0;
    logic                 m_valid;
    logic                 m_ready        = 1'b0;
    logic [VALUE_W-1:0]   m_current_value;
    logic                 m_is_done;
    logic                 m_finished_now;

    int     mismatches;
    int     outstanding;
    longint elapsed_sent   = 0;
    longint dur_now        = 0;
    int     ticks_live     = 0;
    int     ticks_after    = 0;
    int     settings_used  = 0;
    int     burst_left     = 0;
    int     cycle_count    = 0;
    string  finish_how;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    eased_tween_interpolator u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_time_step_us  (s_time_step_us),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_current_value (m_current_value),
        .m_is_done       (m_is_done),
        .m_finished_now  (m_finished_now)
    );

    etw_tween_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_time_step_us  (s_time_step_us),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_current_value (m_current_value),
        .m_is_done       (m_is_done),
        .m_finished_now  (m_finished_now),
        .mismatches      (mismatches),
        .outstanding     (outstanding)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, outstanding);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver stalls on a rotating mask, redrawn now and then; bit 0 stays clear
    logic [15:0] rx_mask = '0;
    int          rx_pos  = 0;
    int          rx_age  = 0;
    always @(posedge aclk) begin
        if (rx_age == 0) begin
            case ($urandom_range(0, 3))
                0:       rx_mask = '0;
                1:       rx_mask = 16'($urandom & $urandom);
                default: rx_mask = 16'($urandom);
            endcase
            rx_mask[0] = 1'b0;
        end
        m_ready <= !rx_mask[rx_pos];
        rx_pos = (rx_pos + 1) % 16;
        rx_age = (rx_age + 1) % 300;
    end

    // leaves cfg_valid high so back-to-back writes need no lowering in between
    task automatic write_reg(input etw_reg_t idx, input logic [VALUE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic close_cfg();
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic send_tick(input logic [STEP_W-1:0] step);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 24);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid        <= 1'b1;
        s_time_step_us <= step;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        elapsed_sent += step;
    endtask

    // the pending count is registered, so look only from the next edge on
    task automatic settle();
        s_valid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        etw_ease_t         shapes[3];
        logic [STEP_W-1:0] step;
        logic [VALUE_W-1:0] level;
        longint            room;
        int                n;

        shapes = '{EASE_IN, EASE_OUT, EASE_IN_OUT};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // widest positive span, linear, smallest and largest steps
        write_reg(REG_START, 32'h8000_0000);
        write_reg(REG_END, 32'h7FFF_FFFF);
        write_reg(REG_DURATION, VALUE_W'(DUR_FULL));
        write_reg(REG_EASE, EASE_LINEAR);
        close_cfg();
        send_tick('0);
        send_tick(STEP_W'(1));
        send_tick('1);
        settle();
        ticks_live += 3;

        // each curve at low progress, then close to the end
        for (int k = 0; k < 3; k++) begin
            write_reg(REG_EASE, shapes[k]);
            write_reg(REG_DURATION, VALUE_W'(DUR_FULL));
            close_cfg();
            send_tick(STEP_W'(17'h10000));
            settle();
            dur_now = elapsed_sent + 3;
            write_reg(REG_DURATION, VALUE_W'(dur_now));
            close_cfg();
            send_tick(STEP_W'(1));
            send_tick(STEP_W'(1));
            settle();
            ticks_live += 3;
        end

        // falling span with progress exactly one half on the in-out knee
        write_reg(REG_START, 32'h7FFF_FFFF);
        write_reg(REG_END, 32'h8000_0000);
        dur_now = 2 * (elapsed_sent + 2);
        write_reg(REG_DURATION, VALUE_W'(dur_now));
        close_cfg();
        send_tick(STEP_W'(2));
        settle();

        // zero span
        level = $urandom;
        write_reg(REG_START, level);
        write_reg(REG_END, level);
        dur_now = DUR_FULL;
        write_reg(REG_DURATION, VALUE_W'(dur_now));
        close_cfg();
        send_tick(STEP_W'(5));
        settle();
        ticks_live += 2;

        // random settings, each keeping the tween short of its end
        while (ticks_live < RANDOM_TICKS) begin
            case ($urandom_range(0, 7))
                0, 1:    dur_now = DUR_FULL;
                2:       dur_now = elapsed_sent + $urandom_range(1, 64);
                3:       dur_now = $urandom_range(int'(elapsed_sent) + 1, int'(DUR_FULL));
                default: dur_now = elapsed_sent + $urandom_range(1, 1 << 20);
            endcase
            if (dur_now > DUR_FULL)
                dur_now = DUR_FULL;
            write_reg(REG_DURATION, VALUE_W'(dur_now));
            if ($urandom_range(0, 1))
                write_reg(REG_START, pick_value());
            if ($urandom_range(0, 1))
                write_reg(REG_END, pick_value());
            if ($urandom_range(0, 1))
                write_reg(REG_EASE, VALUE_W'($urandom_range(0, 3)));
            close_cfg();
            n = $urandom_range(20, 150);
            repeat (n) begin
                room = dur_now - 1 - elapsed_sent;
                case ($urandom_range(0, 31))
                    0:          step = STEP_W'($urandom);
                    1:          step = '0;
                    2, 3, 4, 5: step = STEP_W'($urandom_range(0, 255));
                    default:    step = STEP_W'($urandom_range(0, 4000));
                endcase
                // keep some headroom for the late settings
                if (elapsed_sent > 12_000_000 && step > 63)
                    step = step & 63;
                if (longint'(step) > room)
                    step = STEP_W'($urandom_range(0, int'(room)));
                send_tick(step);
                ticks_live++;
            end
            settle();
        end

        // one way to complete the tween
        case ($urandom_range(0, 2))
            0: begin
                finish_how = "a zero duration";
                write_reg(REG_DURATION, '0);
                close_cfg();
                send_tick(STEP_W'($urandom));
                ticks_live++;
            end
            1: begin
                finish_how = "a duration cut below the elapsed time";
                write_reg(REG_DURATION, VALUE_W'($urandom_range(1, int'(elapsed_sent))));
                close_cfg();
                send_tick(STEP_W'($urandom_range(0, 4000)));
                ticks_live++;
            end
            default: begin
                finish_how = "the elapsed time running out";
                dur_now = elapsed_sent + $urandom_range(1, 50000);
                write_reg(REG_DURATION, VALUE_W'(dur_now));
                close_cfg();
                while (elapsed_sent < dur_now) begin
                    send_tick(STEP_W'($urandom_range(0, 20000)));
                    ticks_live++;
                end
            end
        endcase
        settle();

        // register writes must not restart a finished tween
        write_reg(REG_START, pick_value());
        write_reg(REG_END, pick_value());
        write_reg(REG_EASE, VALUE_W'($urandom_range(0, 3)));
        write_reg(REG_DURATION, VALUE_W'(DUR_FULL));
        close_cfg();
        repeat (40) begin
            send_tick(STEP_W'($urandom));
            ticks_after++;
        end
        settle();
        repeat (70) @(posedge aclk);

        $display("summary: %0d live ticks over %0d register settings, %0d ticks after completion",
                 ticks_live, settings_used, ticks_after);
        $display("summary: tween completed by %s", finish_how);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
